// ----- rtl/tvta_pkg.sv -----
// Package for the voted transit authentication block: item, result and
// register types, state and event codes, and fixed limits.
// No dependencies; every file but tvta_if imports it.
package tvta_pkg;

  localparam logic [7:0]  STUCK_LIMIT = 8'd100;
  localparam logic [31:0] SCRUB_LIMIT = 32'd1000;
  localparam logic [13:0] DARK_LEVEL  = 14'd5000;

  localparam logic [15:0] FULL_TURN = 16'd36000;
  localparam logic [15:0] HALF_TURN = 16'd18000;

  localparam logic [2:0] ST_LOCKED    = 3'd0;
  localparam logic [2:0] ST_ARMED     = 3'd1;
  localparam logic [2:0] ST_VERIFYING = 3'd2;
  localparam logic [2:0] ST_AUTH      = 3'd3;
  localparam logic [2:0] ST_FAULTED   = 3'd4;

  localparam int EV_INGRESS = 0;
  localparam int EV_SUCCESS = 1;
  localparam int EV_PRESET  = 2;
  localparam int EV_STAB    = 3;
  localparam int EV_TMR     = 4;
  localparam int EV_AFAIL   = 5;

  localparam logic [1:0] HEALTH_FULL     = 2'd0;
  localparam logic [1:0] HEALTH_DEGRADED = 2'd1;
  localparam logic [1:0] HEALTH_VOTEFAIL = 2'd2;

  localparam logic RK_TICK    = 1'b0;
  localparam logic RK_COMMAND = 1'b1;

  localparam logic UPSET_STATE   = 1'b0;
  localparam logic UPSET_PERSIST = 1'b1;

  typedef enum logic [2:0] {
    K_TICK        = 3'd0,
    K_YAW         = 3'd1,
    K_LIGHT       = 3'd2,
    K_AUTH_START  = 3'd3,
    K_AUTH_RESET  = 3'd4,
    K_SCHED_LOAD  = 3'd5,
    K_UPSET       = 3'd6
  } kind_t;

  typedef enum logic [2:0] {
    CFG_WINDOW_START    = 3'd0,
    CFG_WINDOW_END      = 3'd1,
    CFG_TARGET_YAW      = 3'd2,
    CFG_STABILITY_LIMIT = 3'd3,
    CFG_INGRESS_LIMIT   = 3'd4,
    CFG_AUTH_COUNT      = 3'd5,
    CFG_NOISE_FLOOR     = 3'd6,
    CFG_BYPASS_KEY      = 3'd7
  } cfg_index_t;

  typedef struct packed {
    logic [31:0]        window_start;
    logic [31:0]        window_end;
    logic [15:0]        target_yaw;
    logic [14:0]        stability_limit;
    logic signed [14:0] ingress_limit;
    logic [15:0]        auth_count;
    logic [13:0]        noise_floor;
    logic [31:0]        bypass_key;
  } cfg_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [31:0] time_sec;
    logic [15:0] yaw_value;
    logic [13:0] light_level;
    logic [31:0] offered_key;
    logic [1:0]  upset_copy;
    logic        upset_field;
    logic [15:0] upset_mask;
  } item_t;

  typedef struct packed {
    logic        report_kind;
    logic [31:0] heartbeat;
    logic [2:0]  fsm_state;
    logic        vote_failed;
    logic [15:0] persistence;
    logic [1:0]  health;
    logic [5:0]  event_flags;
    logic        bypass;
    logic        command_ok;
  } rpt_t;

endpackage

// ----- rtl/tvta_if.sv -----
// Channel interfaces for the voted transit authentication block:
// command items, report items and configuration writes.
// Standalone; widths follow the item and register fields.
interface tvta_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  kind;
  logic [31:0] time_sec;
  logic [15:0] yaw_value;
  logic [13:0] light_level;
  logic [31:0] offered_key;
  logic [1:0]  upset_copy;
  logic        upset_field;
  logic [15:0] upset_mask;

  modport source (output valid, kind, time_sec, yaw_value, light_level, offered_key,
                  upset_copy, upset_field, upset_mask, input ready);
  modport sink (input valid, kind, time_sec, yaw_value, light_level, offered_key,
                upset_copy, upset_field, upset_mask, output ready);
endinterface

interface tvta_out_if;
  logic        valid;
  logic        ready;
  logic        report_kind;
  logic [31:0] heartbeat;
  logic [2:0]  fsm_state;
  logic        vote_failed;
  logic [15:0] persistence;
  logic [1:0]  health;
  logic [5:0]  event_flags;
  logic        bypass;
  logic        command_ok;

  modport source (output valid, report_kind, heartbeat, fsm_state, vote_failed,
                  persistence, health, event_flags, bypass, command_ok, input ready);
  modport sink (input valid, report_kind, heartbeat, fsm_state, vote_failed,
                persistence, health, event_flags, bypass, command_ok, output ready);
endinterface

interface tvta_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [31:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ----- rtl/tvta_cfg_regs.sv -----
// Configuration register file of the voted transit authentication block.
// Depends on tvta_pkg and the tvta_cfg_if interface.
module tvta_cfg_regs (
  input  logic          clk,
  input  logic          rst,
  tvta_cfg_if.sink      cfg,
  output tvta_pkg::cfg_t regs
);
  import tvta_pkg::*;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.window_start    <= 32'd0;
      regs.window_end      <= 32'd0;
      regs.target_yaw      <= 16'd0;
      regs.stability_limit <= 15'd500;
      regs.ingress_limit   <= -15'sd500;
      regs.auth_count      <= 16'd10;
      regs.noise_floor     <= 14'd1000;
      regs.bypass_key      <= 32'd0;
    end else if (cfg.valid && cfg.ready) begin
      case (cfg_index_t'(cfg.index))
        CFG_WINDOW_START:    regs.window_start    <= cfg.data;
        CFG_WINDOW_END:      regs.window_end      <= cfg.data;
        CFG_TARGET_YAW:      regs.target_yaw      <= cfg.data[15:0];
        CFG_STABILITY_LIMIT: regs.stability_limit <= cfg.data[14:0];
        CFG_INGRESS_LIMIT:   regs.ingress_limit   <= $signed(cfg.data[14:0]);
        CFG_AUTH_COUNT:      regs.auth_count      <= cfg.data[15:0];
        CFG_NOISE_FLOOR:     regs.noise_floor     <= cfg.data[13:0];
        CFG_BYPASS_KEY:      regs.bypass_key      <= cfg.data;
        default: ;
      endcase
    end
  end

endmodule

// ----- rtl/tvta_core.sv -----
// Voted state machine core: triple copies of state and persistence, vote and scrub,
// stuck-light check, transitions and command handling, one item a cycle while acc is set.
// Depends on tvta_pkg.
module tvta_core (
  input  logic           clk,
  input  logic           rst,
  input  tvta_pkg::cfg_t cfg,
  input  logic           acc,
  input  tvta_pkg::item_t item,
  output logic           res_valid,
  output tvta_pkg::rpt_t res
);
  import tvta_pkg::*;

  logic [2:0]  sc [3];
  logic [15:0] pc [3];
  logic [2:0]  sc_next [3];
  logic [15:0] pc_next [3];
  logic [31:0] tick_count, tick_count_next;
  logic [31:0] scrub_total, scrub_total_next;
  logic        stable_flag, stable_flag_next;
  logic [15:0] heading_now, heading_now_next;
  logic [13:0] light_now, light_now_next;
  logic [13:0] light_prev, light_prev_next;
  logic [13:0] light_last, light_last_next;
  logic [7:0]  stuck_count, stuck_count_next;
  logic [31:0] last_auth_start, last_auth_start_next;

  logic        s_ok, p_ok;
  logic [2:0]  s_vote;
  logic [15:0] p_vote;
  logic [2:0]  n_scrub;
  logic [31:0] scrub_sum;
  logic signed [14:0] slope;
  logic        in_window;
  logic [15:0] yaw_diff, yaw_mod, yaw_err;
  logic [7:0]  stuck_inc;
  logic [15:0] pers_inc;

  assign s_ok   = (sc[0] == sc[1]) || (sc[0] == sc[2]) || (sc[1] == sc[2]);
  assign s_vote = ((sc[0] == sc[1]) || (sc[0] == sc[2])) ? sc[0] :
                  (sc[1] == sc[2]) ? sc[1] : 3'd0;
  assign p_ok   = (pc[0] == pc[1]) || (pc[0] == pc[2]) || (pc[1] == pc[2]);
  assign p_vote = ((pc[0] == pc[1]) || (pc[0] == pc[2])) ? pc[0] :
                  (pc[1] == pc[2]) ? pc[1] : 16'd0;

  assign n_scrub = (s_ok ? (3'(sc[0] != s_vote) + 3'(sc[1] != s_vote) + 3'(sc[2] != s_vote))
                         : 3'd0)
                 + 3'(pc[0] != p_vote) + 3'(pc[1] != p_vote) + 3'(pc[2] != p_vote);
  assign scrub_sum = (scrub_total > (32'hFFFF_FFFF - 32'(n_scrub))) ? 32'hFFFF_FFFF
                   : scrub_total + 32'(n_scrub);

  assign slope     = $signed({1'b0, light_now}) - $signed({1'b0, light_prev});
  assign in_window = (item.time_sec >= cfg.window_start) &&
                     (item.time_sec <= cfg.window_end);

  assign yaw_diff = (heading_now > cfg.target_yaw) ? heading_now - cfg.target_yaw
                                                   : cfg.target_yaw - heading_now;
  assign yaw_mod  = (yaw_diff >= FULL_TURN) ? yaw_diff - FULL_TURN : yaw_diff;
  assign yaw_err  = (yaw_mod > HALF_TURN) ? FULL_TURN - yaw_mod : yaw_mod;

  assign stuck_inc = (stuck_count == 8'hFF) ? stuck_count : stuck_count + 8'd1;
  assign pers_inc  = (p_vote == 16'hFFFF) ? p_vote : p_vote + 16'd1;

  always_comb begin
    logic [2:0]  st_from;
    logic [2:0]  st_new;
    logic [15:0] pers_new;
    logic [15:0] pers_out;
    logic [5:0]  ev;
    logic [1:0]  hl;
    st_from  = ST_LOCKED;
    st_new   = ST_LOCKED;
    pers_new = 16'd0;
    pers_out = 16'd0;
    ev       = 6'd0;
    hl       = HEALTH_FULL;

    sc_next              = sc;
    pc_next              = pc;
    tick_count_next      = tick_count;
    scrub_total_next     = scrub_total;
    stable_flag_next     = stable_flag;
    heading_now_next     = heading_now;
    light_now_next       = light_now;
    light_prev_next      = light_prev;
    light_last_next      = light_last;
    stuck_count_next     = stuck_count;
    last_auth_start_next = last_auth_start;
    res_valid            = 1'b0;
    res                  = '0;
    res.heartbeat        = tick_count;
    res.report_kind      = RK_COMMAND;

    if (acc) begin
      case (kind_t'(item.kind))
        K_TICK: begin
          tick_count_next  = tick_count + 32'd1;
          scrub_total_next = scrub_sum;
          if (!s_ok) begin
            ev[EV_TMR] = 1'b1;
            hl         = HEALTH_VOTEFAIL;
            st_new     = ST_FAULTED;
          end else begin
            st_new = s_vote;
          end
          if (scrub_sum > SCRUB_LIMIT) begin
            hl = HEALTH_DEGRADED;
          end
          pers_new = p_vote;
          pers_out = p_vote;

          if (light_now > cfg.noise_floor) begin
            if (light_now == light_last) begin
              stuck_count_next = stuck_inc;
              if (stuck_inc > STUCK_LIMIT) begin
                st_new = ST_FAULTED;
              end
            end else begin
              stuck_count_next = 8'd0;
            end
          end
          light_last_next = light_now;

          st_from = st_new;
          case (st_from)
            ST_LOCKED: begin
              if (in_window && (last_auth_start != cfg.window_start)) begin
                st_new = ST_ARMED;
              end
            end
            ST_ARMED: begin
              if (!in_window) begin
                st_new = ST_LOCKED;
              end else if (({1'b0, cfg.stability_limit} >= yaw_err) &&
                           (slope <= cfg.ingress_limit)) begin
                st_new          = ST_VERIFYING;
                pers_new        = 16'd0;
                ev[EV_INGRESS]  = 1'b1;
              end
            end
            ST_VERIFYING: begin
              if (light_now < DARK_LEVEL) begin
                pers_out = pers_inc;
                pers_new = pers_inc;
                if (pers_inc >= cfg.auth_count) begin
                  st_new = ST_AUTH;
                end
              end else begin
                st_new        = ST_ARMED;
                pers_new      = 16'd0;
                ev[EV_PRESET] = 1'b1;
              end
            end
            ST_AUTH: begin
              ev[EV_SUCCESS]       = 1'b1;
              last_auth_start_next = cfg.window_start;
              st_new               = ST_LOCKED;
            end
            ST_FAULTED: begin
              if (stable_flag) begin
                ev[EV_STAB]      = 1'b1;
                stable_flag_next = 1'b0;
              end
            end
            default: begin
              ev[EV_TMR] = 1'b1;
              st_new     = ST_FAULTED;
            end
          endcase
          light_prev_next = light_now;

          for (int i = 0; i < 3; i++) begin
            sc_next[i] = st_new;
            pc_next[i] = pers_new;
          end
          res_valid       = 1'b1;
          res.report_kind = RK_TICK;
          res.heartbeat   = tick_count + 32'd1;
          res.fsm_state   = st_from;
          res.vote_failed = !s_ok;
          res.persistence = pers_out;
          res.health      = hl;
          res.event_flags = ev;
        end
        K_YAW: begin
          heading_now_next = item.yaw_value;
        end
        K_LIGHT: begin
          light_now_next = item.light_level;
        end
        K_AUTH_START: begin
          res_valid = 1'b1;
          if (item.offered_key == cfg.bypass_key) begin
            for (int i = 0; i < 3; i++) begin
              sc_next[i] = ST_AUTH;
            end
            res.event_flags[EV_SUCCESS] = 1'b1;
            res.bypass                  = 1'b1;
            res.command_ok              = 1'b1;
          end else begin
            res.event_flags[EV_AFAIL] = 1'b1;
          end
        end
        K_AUTH_RESET: begin
          for (int i = 0; i < 3; i++) begin
            sc_next[i] = ST_LOCKED;
            pc_next[i] = 16'd0;
          end
          stable_flag_next = 1'b1;
          res_valid        = 1'b1;
          res.command_ok   = 1'b1;
        end
        K_SCHED_LOAD: begin
          res_valid = 1'b1;
        end
        K_UPSET: begin
          if (item.upset_copy != 2'd3) begin
            if (item.upset_field == UPSET_STATE) begin
              sc_next[item.upset_copy] = sc[item.upset_copy] ^ item.upset_mask[2:0];
            end else begin
              pc_next[item.upset_copy] = pc[item.upset_copy] ^ item.upset_mask;
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 3; i++) begin
        sc[i] <= ST_LOCKED;
        pc[i] <= 16'd0;
      end
      tick_count      <= 32'd0;
      scrub_total     <= 32'd0;
      stable_flag     <= 1'b1;
      heading_now     <= 16'd0;
      light_now       <= 14'd10000;
      light_prev      <= 14'd10000;
      light_last      <= 14'd10000;
      stuck_count     <= 8'd0;
      last_auth_start <= 32'd0;
    end else begin
      sc              <= sc_next;
      pc              <= pc_next;
      tick_count      <= tick_count_next;
      scrub_total     <= scrub_total_next;
      stable_flag     <= stable_flag_next;
      heading_now     <= heading_now_next;
      light_now       <= light_now_next;
      light_prev      <= light_prev_next;
      light_last      <= light_last_next;
      stuck_count     <= stuck_count_next;
      last_auth_start <= last_auth_start_next;
    end
  end

  a_tick_state_scrubbed: assert property (@(posedge clk) disable iff (rst)
    (acc && item.kind == K_TICK) |=> (sc[0] == sc[1] && sc[1] == sc[2]))
    else $error("state copies differ after a tick");

  a_tick_persist_scrubbed: assert property (@(posedge clk) disable iff (rst)
    (acc && item.kind == K_TICK) |=> (pc[0] == pc[1] && pc[1] == pc[2]))
    else $error("persistence copies differ after a tick");

  a_reset_cmd_locks: assert property (@(posedge clk) disable iff (rst)
    (acc && item.kind == K_AUTH_RESET) |=>
      (sc[0] == ST_LOCKED && sc[1] == ST_LOCKED && sc[2] == ST_LOCKED &&
       pc[0] == 16'd0 && stable_flag))
    else $error("auth reset did not lock the machine");

  a_vote_fail_faults: assert property (@(posedge clk) disable iff (rst)
    (acc && item.kind == K_TICK && !s_ok) |=> (sc[0] == ST_FAULTED))
    else $error("total vote failure did not force fault");

endmodule

// ----- rtl/tvta_out_buf.sv -----
// Two-entry report buffer: output register plus skid stage, so a new item is
// taken while a report waits. Depends on tvta_pkg.
module tvta_out_buf (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  tvta_pkg::rpt_t push_data,
  output logic           space,
  output logic           out_valid,
  input  logic           out_ready,
  output tvta_pkg::rpt_t out_data
);
  import tvta_pkg::*;

  logic main_v, skid_v;
  rpt_t main_d, skid_d;

  assign space     = !skid_v;
  assign out_valid = main_v;
  assign out_data  = main_d;

  always_ff @(posedge clk) begin
    if (rst) begin
      main_v <= 1'b0;
      skid_v <= 1'b0;
    end else if (main_v && out_ready) begin
      if (skid_v) begin
        main_v <= 1'b1;
        skid_v <= 1'b0;
      end else begin
        main_v <= push;
      end
    end else if (push) begin
      if (main_v) begin
        skid_v <= 1'b1;
      end else begin
        main_v <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (main_v && out_ready) begin
      if (skid_v) begin
        main_d <= skid_d;
      end else if (push) begin
        main_d <= push_data;
      end
    end else if (push) begin
      if (main_v) begin
        skid_d <= push_data;
      end else begin
        main_d <= push_data;
      end
    end
  end

  a_skid_behind_main: assert property (@(posedge clk) disable iff (rst)
    skid_v |-> main_v)
    else $error("skid entry held with empty output register");

  a_no_push_when_full: assert property (@(posedge clk) disable iff (rst)
    (skid_v && !out_ready) |=> skid_v && $stable(skid_d))
    else $error("skid entry lost or overwritten");

endmodule

// ----- rtl/tmr_voted_transit_auth_fsm.sv -----
// Top level of the triple-voted transit authentication machine.
// Reports are registered: output register, or skid stage first while one waits.
// Throughput: one item per cycle; a two-entry output buffer keeps input open
// while a report waits, and input stalls only when both entries are full.
// Reset (rst, synchronous): copies locked, counters cleared, registers to defaults.
// Depends on tvta_pkg, tvta_if, tvta_cfg_regs, tvta_core and tvta_out_buf.
module tmr_voted_transit_auth_fsm (
  input logic        clk,
  input logic        rst,
  tvta_cfg_if.sink   cfg,
  tvta_in_if.sink    cmd,
  tvta_out_if.source rpt
);
  import tvta_pkg::*;

  cfg_t  regs;
  item_t item;
  rpt_t  res, out_data;
  logic  res_valid, space, acc;

  assign item.kind        = cmd.kind;
  assign item.time_sec    = cmd.time_sec;
  assign item.yaw_value   = cmd.yaw_value;
  assign item.light_level = cmd.light_level;
  assign item.offered_key = cmd.offered_key;
  assign item.upset_copy  = cmd.upset_copy;
  assign item.upset_field = cmd.upset_field;
  assign item.upset_mask  = cmd.upset_mask;

  assign cmd.ready = space;
  assign acc       = cmd.valid && space;

  tvta_cfg_regs u_cfg (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .regs (regs)
  );

  tvta_core u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg       (regs),
    .acc       (acc),
    .item      (item),
    .res_valid (res_valid),
    .res       (res)
  );

  tvta_out_buf u_buf (
    .clk       (clk),
    .rst       (rst),
    .push      (res_valid),
    .push_data (res),
    .space     (space),
    .out_valid (rpt.valid),
    .out_ready (rpt.ready),
    .out_data  (out_data)
  );

  assign rpt.report_kind = out_data.report_kind;
  assign rpt.heartbeat   = out_data.heartbeat;
  assign rpt.fsm_state   = out_data.fsm_state;
  assign rpt.vote_failed = out_data.vote_failed;
  assign rpt.persistence = out_data.persistence;
  assign rpt.health      = out_data.health;
  assign rpt.event_flags = out_data.event_flags;
  assign rpt.bypass      = out_data.bypass;
  assign rpt.command_ok  = out_data.command_ok;

endmodule

// ----- tb/tb_tmr_voted_transit_auth_fsm.sv -----
// Self-checking testbench for the triple-voted transit authentication machine.
// Drives command items, predicts each report with an in-bench model of the
// voted state machine and checks reports in order; needs tvta_pkg, tvta_if and the top.
`timescale 1ns / 1ps

module tb_tmr_voted_transit_auth_fsm;
  import tvta_pkg::*;

  localparam logic [2:0] K_UNUSED = 3'd7;

  logic clk;
  logic rst;

  tvta_cfg_if cfg_if ();
  tvta_in_if  cmd_if ();
  tvta_out_if rpt_if ();

  tmr_voted_transit_auth_fsm i_dut (
    .clk (clk),
    .rst (rst),
    .cfg (cfg_if),
    .cmd (cmd_if),
    .rpt (rpt_if)
  );

  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  // Model of the machine
  cfg_t        regs;
  logic [2:0]  copy_state [3];
  logic [15:0] copy_persist [3];
  logic [31:0] tick_total;
  logic [31:0] scrub_count;
  logic [31:0] armed_start;
  logic        alert_armed;
  logic [15:0] heading;
  logic [13:0] light_cur;
  logic [13:0] light_prev;
  logic [13:0] light_seen;
  logic [7:0]  stuck_run;

  rpt_t pending_reports [$];
  int   fail_count = 0;
  int   item_count = 0;
  bit   quiet = 1'b0;
  int   rpt_hold = 0;

  function automatic int draw_gap();
    return quiet ? 0 : $urandom_range(0, 6);
  endfunction

  function automatic logic [15:0] majority(input logic [15:0] a, b, c, output bit agreed);
    agreed = 1'b1;
    if (a == b || a == c) return a;
    if (b == c) return b;
    agreed = 1'b0;
    return 16'd0;
  endfunction

  task automatic set_all_state(input logic [2:0] s);
    for (int i = 0; i < 3; i++) copy_state[i] = s;
  endtask

  task automatic set_all_persist(input logic [15:0] p);
    for (int i = 0; i < 3; i++) copy_persist[i] = p;
  endtask

  task automatic bump_scrub();
    if (scrub_count != 32'hFFFF_FFFF) scrub_count++;
  endtask

  task automatic reset_model();
    regs.window_start    = 32'd0;
    regs.window_end      = 32'd0;
    regs.target_yaw      = 16'd0;
    regs.stability_limit = 15'd500;
    regs.ingress_limit   = -15'sd500;
    regs.auth_count      = 16'd10;
    regs.noise_floor     = 14'd1000;
    regs.bypass_key      = 32'd0;
    set_all_state(ST_LOCKED);
    set_all_persist(16'd0);
    tick_total  = 32'd0;
    scrub_count = 32'd0;
    armed_start = 32'd0;
    alert_armed = 1'b1;
    heading     = 16'd0;
    light_cur   = 14'd10000;
    light_prev  = 14'd10000;
    light_seen  = 14'd10000;
    stuck_run   = 8'd0;
  endtask

  task automatic tick_step(input logic [31:0] now);
    rpt_t        r;
    logic [15:0] v;
    logic [15:0] pers;
    logic [15:0] err;
    logic [2:0]  cur;
    logic [5:0]  ev;
    logic [1:0]  hl;
    logic        vf;
    bit          ok;
    bit          in_win;
    int          slope;
    int          ilim;
    int          lnow;
    int          lprev;
    ev = 6'd0;
    hl = HEALTH_FULL;
    vf = 1'b0;
    tick_total++;
    v = majority(copy_state[0], copy_state[1], copy_state[2], ok);
    if (!ok) begin
      ev[EV_TMR] = 1'b1;
      set_all_state(ST_FAULTED);
      hl = HEALTH_VOTEFAIL;
      vf = 1'b1;
    end else begin
      for (int i = 0; i < 3; i++)
        if (copy_state[i] != v[2:0]) begin
          copy_state[i] = v[2:0];
          bump_scrub();
        end
    end
    pers = majority(copy_persist[0], copy_persist[1], copy_persist[2], ok);
    for (int i = 0; i < 3; i++)
      if (copy_persist[i] != pers) begin
        copy_persist[i] = pers;
        bump_scrub();
      end
    if (scrub_count > SCRUB_LIMIT) hl = HEALTH_DEGRADED;

    lnow   = light_cur;
    lprev  = light_prev;
    slope  = lnow - lprev;
    ilim   = $signed(regs.ingress_limit);
    in_win = (now >= regs.window_start) && (now <= regs.window_end);

    if (light_cur > regs.noise_floor) begin
      if (light_cur == light_seen) begin
        if (stuck_run != 8'hFF) stuck_run++;
        if (stuck_run > STUCK_LIMIT) set_all_state(ST_FAULTED);
      end else begin
        stuck_run = 8'd0;
      end
    end
    light_seen = light_cur;

    v   = majority(copy_state[0], copy_state[1], copy_state[2], ok);
    cur = v[2:0];
    case (cur)
      ST_LOCKED: begin
        if (in_win && armed_start != regs.window_start) set_all_state(ST_ARMED);
      end
      ST_ARMED: begin
        if (!in_win) begin
          set_all_state(ST_LOCKED);
        end else begin
          err = (heading > regs.target_yaw) ? heading - regs.target_yaw
                                            : regs.target_yaw - heading;
          err = err % FULL_TURN;
          if (err > HALF_TURN) err = FULL_TURN - err;
          if (err <= regs.stability_limit && slope <= ilim) begin
            set_all_state(ST_VERIFYING);
            set_all_persist(16'd0);
            ev[EV_INGRESS] = 1'b1;
          end
        end
      end
      ST_VERIFYING: begin
        if (light_cur < DARK_LEVEL) begin
          if (pers != 16'hFFFF) pers++;
          set_all_persist(pers);
          if (pers >= regs.auth_count) set_all_state(ST_AUTH);
        end else begin
          set_all_state(ST_ARMED);
          set_all_persist(16'd0);
          ev[EV_PRESET] = 1'b1;
        end
      end
      ST_AUTH: begin
        ev[EV_SUCCESS] = 1'b1;
        armed_start = regs.window_start;
        set_all_state(ST_LOCKED);
      end
      ST_FAULTED: begin
        if (alert_armed) begin
          ev[EV_STAB] = 1'b1;
          alert_armed = 1'b0;
        end
      end
      default: begin
        ev[EV_TMR] = 1'b1;
        set_all_state(ST_FAULTED);
      end
    endcase
    light_prev = light_cur;

    r             = '0;
    r.report_kind = RK_TICK;
    r.heartbeat   = tick_total;
    r.fsm_state   = cur;
    r.vote_failed = vf;
    r.persistence = pers;
    r.health      = hl;
    r.event_flags = ev;
    pending_reports.push_back(r);
  endtask

  task automatic auth_machine_step(input item_t it);
    rpt_t r;
    r             = '0;
    r.report_kind = RK_COMMAND;
    r.heartbeat   = tick_total;
    case (it.kind)
      K_TICK: tick_step(it.time_sec);
      K_YAW: heading = it.yaw_value;
      K_LIGHT: light_cur = it.light_level;
      K_AUTH_START: begin
        if (it.offered_key == regs.bypass_key) begin
          set_all_state(ST_AUTH);
          r.event_flags[EV_SUCCESS] = 1'b1;
          r.bypass = 1'b1;
          r.command_ok = 1'b1;
        end else begin
          r.event_flags[EV_AFAIL] = 1'b1;
        end
        pending_reports.push_back(r);
      end
      K_AUTH_RESET: begin
        set_all_state(ST_LOCKED);
        set_all_persist(16'd0);
        alert_armed = 1'b1;
        r.command_ok = 1'b1;
        pending_reports.push_back(r);
      end
      K_SCHED_LOAD: pending_reports.push_back(r);
      K_UPSET: begin
        if (it.upset_copy < 2'd3) begin
          if (it.upset_field == UPSET_STATE)
            copy_state[it.upset_copy] = copy_state[it.upset_copy] ^ it.upset_mask[2:0];
          else
            copy_persist[it.upset_copy] = copy_persist[it.upset_copy] ^ it.upset_mask;
        end
      end
      default: ;
    endcase
  endtask

  // Stimulus
  task automatic send_item(input item_t it);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      cmd_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cmd_if.valid       <= 1'b1;
    cmd_if.kind        <= it.kind;
    cmd_if.time_sec    <= it.time_sec;
    cmd_if.yaw_value   <= it.yaw_value;
    cmd_if.light_level <= it.light_level;
    cmd_if.offered_key <= it.offered_key;
    cmd_if.upset_copy  <= it.upset_copy;
    cmd_if.upset_field <= it.upset_field;
    cmd_if.upset_mask  <= it.upset_mask;
    @(posedge clk);
    while (!cmd_if.ready) @(posedge clk);
    auth_machine_step(it);
    item_count++;
  endtask

  function automatic item_t make_item(input logic [2:0] k);
    item_t it;
    it.kind        = k;
    it.time_sec    = $urandom;
    it.yaw_value   = 16'($urandom);
    it.light_level = 14'($urandom);
    it.offered_key = $urandom;
    it.upset_copy  = 2'($urandom);
    it.upset_field = 1'($urandom);
    it.upset_mask  = 16'($urandom);
    return it;
  endfunction

  task automatic tick(input logic [31:0] now);
    item_t it;
    it = make_item(K_TICK);
    it.time_sec = now;
    send_item(it);
  endtask

  task automatic set_yaw(input logic [15:0] v);
    item_t it;
    it = make_item(K_YAW);
    it.yaw_value = v;
    send_item(it);
  endtask

  task automatic set_light(input logic [13:0] v);
    item_t it;
    it = make_item(K_LIGHT);
    it.light_level = v;
    send_item(it);
  endtask

  task automatic upset(input logic [1:0] cp, input logic fld, input logic [15:0] m);
    item_t it;
    it = make_item(K_UPSET);
    it.upset_copy  = cp;
    it.upset_field = fld;
    it.upset_mask  = m;
    send_item(it);
  endtask

  task automatic command(input logic [2:0] k, input logic [31:0] key);
    item_t it;
    it = make_item(k);
    it.offered_key = key;
    send_item(it);
  endtask

  function automatic logic [31:0] win_time();
    if (regs.window_end >= regs.window_start && $urandom_range(0, 11) != 0)
      return regs.window_start + $urandom_range(0, regs.window_end - regs.window_start);
    return $urandom;
  endfunction

  task automatic settle();
    cmd_if.valid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_index_t idx, input logic [31:0] data);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= data;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
  endtask

  task automatic program_regs(input cfg_t c);
    write_reg(CFG_WINDOW_START, c.window_start);
    write_reg(CFG_WINDOW_END, c.window_end);
    write_reg(CFG_TARGET_YAW, {16'd0, c.target_yaw});
    write_reg(CFG_STABILITY_LIMIT, {17'd0, c.stability_limit});
    write_reg(CFG_INGRESS_LIMIT, {17'd0, c.ingress_limit});
    write_reg(CFG_AUTH_COUNT, {16'd0, c.auth_count});
    write_reg(CFG_NOISE_FLOOR, {18'd0, c.noise_floor});
    write_reg(CFG_BYPASS_KEY, c.bypass_key);
    cfg_if.valid <= 1'b0;
    regs = c;
  endtask

  task automatic test_directed_cases();
    command(K_SCHED_LOAD, $urandom);
    command(K_UNUSED, $urandom);
    command(K_AUTH_START, 32'hFFFF_FFFF);
    tick(32'd0);
    tick(32'hFFFF_FFFF);
    set_yaw(16'hFFFF);
    set_light(14'h3FFF);
    tick(32'd0);
    set_light(14'd0);
    tick(32'hFFFF_FFFF);
    upset(2'd3, UPSET_STATE, 16'hFFFF);
    upset(2'd3, UPSET_PERSIST, 16'hFFFF);
    tick($urandom);
    upset(2'd0, UPSET_STATE, 16'd1);
    upset(2'd1, UPSET_STATE, 16'd2);
    tick($urandom);
    tick($urandom);
    command(K_AUTH_RESET, $urandom);
    upset(2'd0, UPSET_STATE, 16'd5);
    upset(2'd1, UPSET_STATE, 16'd5);
    tick($urandom);
    command(K_AUTH_RESET, $urandom);
    upset(2'd0, UPSET_PERSIST, 16'd1);
    upset(2'd1, UPSET_PERSIST, 16'd2);
    tick($urandom);
    command(K_AUTH_START, 32'd0);
    tick($urandom);
    tick($urandom);
  endtask

  task automatic test_stuck_light();
    set_light(14'd12000);
    repeat (258) tick($urandom);
    command(K_AUTH_RESET, $urandom);
    repeat (2) tick($urandom);
  endtask

  task automatic test_persist_saturation();
    cfg_t c;
    settle();
    c.window_start    = 32'd1;
    c.window_end      = 32'hFFFF_FFFF;
    c.target_yaw      = 16'd0;
    c.stability_limit = 15'h7FFF;
    c.ingress_limit   = 15'sh3FFF;
    c.auth_count      = 16'hFFFF;
    c.noise_floor     = 14'h3FFF;
    c.bypass_key      = 32'hFFFF_FFFF;
    program_regs(c);
    set_light(14'd0);
    command(K_AUTH_RESET, $urandom);
    tick(32'd5);
    set_yaw(16'd30000);
    tick(32'd6);
    upset(2'd0, UPSET_PERSIST, 16'hFFFF);
    upset(2'd1, UPSET_PERSIST, 16'hFFFF);
    set_light(14'd100);
    tick(32'd7);
    tick(32'd8);
  endtask

  task automatic test_scrub_degrade();
    repeat (260) begin
      upset(2'd0, UPSET_PERSIST, 16'($urandom_range(1, 65535)));
      upset(2'd1, UPSET_PERSIST, 16'($urandom_range(1, 65535)));
      upset(2'd2, UPSET_PERSIST, 16'($urandom_range(1, 65535)));
      upset(2'($urandom_range(0, 2)), UPSET_STATE, 16'($urandom_range(1, 7)));
      tick($urandom);
    end
  endtask

  task automatic test_random_traffic();
    cfg_t        c;
    int          goal;
    int          phase_end;
    int          span;
    int          lim;
    int          delta;
    int          hd;
    int          hi;
    int          lo;
    int          extra;
    int          ilim;
    int          dark;
    int          pick;
    bit          ok;
    logic [15:0] v;
    goal = item_count + 150;
    while (item_count < goal) begin
      settle();
      c.window_start = $urandom;
      span = $urandom_range(20, 3000);
      if (c.window_start > 32'hFFFF_FFFF - span) c.window_start = c.window_start - span;
      c.window_end = c.window_start + span;
      case ($urandom_range(0, 7))
        0: begin
          c.window_start = 32'd0;
          c.window_end   = 32'hFFFF_FFFF;
        end
        1: c.window_end = c.window_start - 32'd1;
        2: c.window_end = c.window_start;
        default: ;
      endcase
      c.target_yaw = 16'($urandom_range(0, 35999));
      case ($urandom_range(0, 7))
        0: c.stability_limit = 15'd0;
        1: c.stability_limit = 15'h7FFF;
        default: c.stability_limit = 15'($urandom_range(50, 3000));
      endcase
      case ($urandom_range(0, 7))
        0: c.ingress_limit = -15'sd16384;
        1: c.ingress_limit = 15'sd16383;
        default: c.ingress_limit = 15'(-int'($urandom_range(100, 4000)));
      endcase
      c.auth_count = ($urandom_range(0, 9) == 0) ? 16'd0 : 16'($urandom_range(1, 5));
      case ($urandom_range(0, 7))
        0: c.noise_floor = 14'd0;
        1: c.noise_floor = 14'h3FFF;
        default: c.noise_floor = 14'($urandom_range(500, 4000));
      endcase
      c.bypass_key = ($urandom_range(0, 4) == 0) ? 32'd0 : $urandom;
      program_regs(c);
      quiet = ($urandom_range(0, 3) == 0);
      phase_end = item_count + 50;
      while (item_count < phase_end) begin
        pick = $urandom_range(0, 99);
        if (pick < 55) begin
          v = majority(copy_state[0], copy_state[1], copy_state[2], ok);
          if (v[2:0] != ST_LOCKED && v[2:0] != ST_ARMED && $urandom_range(0, 9) < 7)
            command(K_AUTH_RESET, $urandom);
          lim = (regs.stability_limit > HALF_TURN) ? HALF_TURN : regs.stability_limit;
          delta = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 35999)
                                              : $urandom_range(0, lim);
          hd = regs.target_yaw;
          hd = ($urandom_range(0, 1) == 0) ? (hd + delta) % 36000
                                           : (hd + 36000 - delta) % 36000;
          if ($urandom_range(0, 7) == 0 && hd + 36000 <= 65535) hd = hd + 36000;
          set_yaw(16'(hd));
          hi = $urandom_range(5000, 10000);
          set_light(14'(hi));
          tick(win_time());
          extra = $urandom_range(0, 1500);
          ilim = $signed(regs.ingress_limit);
          lo = hi + ilim - extra;
          if (lo < 0) lo = 0;
          if (lo > 16383) lo = 16383;
          set_light(14'(lo));
          tick(win_time());
          dark = (regs.auth_count < 6) ? regs.auth_count : 6;
          repeat (dark + 1) begin
            case ($urandom_range(0, 9))
              0: set_light(14'($urandom_range(5000, 16383)));
              1, 2, 3, 4: set_light(14'($urandom_range(0, 4999)));
              default: ;
            endcase
            tick(win_time());
          end
          tick(win_time());
        end else if (pick < 65) begin
          command(K_AUTH_START, ($urandom_range(0, 1) == 0) ? regs.bypass_key : $urandom);
          repeat ($urandom_range(1, 2)) tick(win_time());
        end else if (pick < 78) begin
          repeat ($urandom_range(1, 4))
            upset(2'($urandom), 1'($urandom), 16'($urandom));
          tick(win_time());
        end else if (pick < 84) begin
          case ($urandom_range(0, 2))
            0: command(K_AUTH_RESET, $urandom);
            1: command(K_SCHED_LOAD, $urandom);
            default: command(K_UNUSED, $urandom);
          endcase
        end else begin
          send_item(make_item(3'($urandom_range(0, 7))));
        end
      end
    end
    quiet = 1'b0;
  endtask

  // Report side: random stalls and in-order checking
  always @(posedge clk) begin
    if (rst) begin
      rpt_hold = 0;
      rpt_if.ready <= 1'b0;
    end else begin
      if (rpt_if.valid && rpt_if.ready) rpt_hold = draw_gap();
      if (rpt_hold > 0) begin
        rpt_hold = rpt_hold - 1;
        rpt_if.ready <= 1'b0;
      end else begin
        rpt_if.ready <= 1'b1;
      end
    end
  end

  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      $display("%0t report %s mismatch: expected %0h, actual %0h", $time, name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin : watch_reports
    rpt_t want;
    if (!rst && rpt_if.valid && rpt_if.ready) begin
      if (pending_reports.size() == 0) begin
        $display("%0t unexpected report: expected none, actual heartbeat %0h kind %0h",
                 $time, rpt_if.heartbeat, rpt_if.report_kind);
        fail_count++;
      end else begin
        want = pending_reports.pop_front();
        check_field("report_kind", want.report_kind, rpt_if.report_kind);
        check_field("heartbeat", want.heartbeat, rpt_if.heartbeat);
        check_field("fsm_state", want.fsm_state, rpt_if.fsm_state);
        check_field("vote_failed", want.vote_failed, rpt_if.vote_failed);
        check_field("persistence", want.persistence, rpt_if.persistence);
        check_field("health", want.health, rpt_if.health);
        check_field("event_flags", want.event_flags, rpt_if.event_flags);
        check_field("bypass", want.bypass, rpt_if.bypass);
        check_field("command_ok", want.command_ok, rpt_if.command_ok);
      end
    end
  end

  initial begin
    #5_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    int guard;
    rst                <= 1'b1;
    cfg_if.valid       <= 1'b0;
    cfg_if.index       <= CFG_WINDOW_START;
    cfg_if.data        <= 32'd0;
    cmd_if.valid       <= 1'b0;
    cmd_if.kind        <= K_TICK;
    cmd_if.time_sec    <= 32'd0;
    cmd_if.yaw_value   <= 16'd0;
    cmd_if.light_level <= 14'd0;
    cmd_if.offered_key <= 32'd0;
    cmd_if.upset_copy  <= 2'd0;
    cmd_if.upset_field <= UPSET_STATE;
    cmd_if.upset_mask  <= 16'd0;
    reset_model();
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    test_directed_cases();
    test_stuck_light();
    test_persist_saturation();
    test_scrub_degrade();
    test_random_traffic();

    cmd_if.valid <= 1'b0;
    guard = 0;
    while (pending_reports.size() != 0 && guard < 20000) begin
      @(posedge clk);
      guard++;
    end
    if (pending_reports.size() != 0) begin
      $display("%0t missing reports: expected %0d more, actual none", $time,
               pending_reports.size());
      fail_count++;
    end
    repeat (10) @(posedge clk);
    if (fail_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
